### rtl/core/light_sensor_i2c_master_top_assert.svh
// Assertion macros for the light sensor I2C master.
// Used by light_sensor_i2c_master_top; needs clk and rst_n in scope.
`ifndef LIGHT_SENSOR_I2C_MASTER_TOP_ASSERT_SVH
`define LIGHT_SENSOR_I2C_MASTER_TOP_ASSERT_SVH

// same-cycle implication
`define LSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lsi2c_pkg.sv
// Shared types and constants for the light sensor I2C master.
// No dependencies.
package lsi2c_pkg;

  typedef enum logic [10:0] {
    PH_IDLE  = 11'b000_0000_0001,
    PH_START = 11'b000_0000_0010,
    PH_TXA   = 11'b000_0000_0100,
    PH_RACKA = 11'b000_0000_1000,
    PH_TXC   = 11'b000_0001_0000,
    PH_RACKC = 11'b000_0010_0000,
    PH_RXH   = 11'b000_0100_0000,
    PH_MACKH = 11'b000_1000_0000,
    PH_RXL   = 11'b001_0000_0000,
    PH_MACKL = 11'b010_0000_0000,
    PH_STOP  = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    MODE_CMD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_PROBE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [6:0] DEV_ADDR_RST = 7'd35;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [0:0] REG_DEV_ADDR = 1'b0;

endpackage

### rtl/core/light_sensor_i2c_master_top.sv
// Light sensor I2C master: input register, one-tick bus sequencer, result register.
// Depends on lsi2c_pkg and light_sensor_i2c_master_top_assert.svh.
//
// Usage: every item on in_ is one bus delay tick. in_tuser carries the
// request flag and the transaction mode (command, read count, probe);
// in_tdata carries the command byte and the SDA level sampled on this tick.
// For each item the block returns exactly one item on out_ with the SCL and
// SDA drive levels, busy, done, ack status and the last light count read.
// A request is taken only while no transaction runs; mode 3 is ignored.
// The slave address comes from the APB register at byte address 0 and is
// loaded into the shift register at the end of the start condition.
// Flow: an accepted item is registered in the input register, stepped once
// through the sequencer and registered in the result register. Throughput:
// one item per cycle while out_tready is high, set by the single-tick
// sequencer step between the two registers. When out_tready is low the
// result register holds, the input register still takes one item, and
// in_tready drops after that.
// Reset (synchronous, rst_n low) empties both registers, puts the sequencer
// in idle with both lines released, and sets the address to 35.
module light_sensor_i2c_master_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // command_byte[7:0], sda_sample[8], zero[15:9]
  input  logic [2:0]  in_tuser,   // request_valid[0], mode[2:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // scl_level[0], sda_level[1], busy_res[2],
                                  // done_res[3], status[4], light_count[20:5], zero[23:21]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [6:0] dev_addr_r;

  logic       s1_valid_r;
  logic       s1_req_r;
  logic [1:0] s1_mode_r;
  logic [7:0] s1_cmd_r;
  logic       s1_sda_r;

  logic        out_valid_r;
  logic [20:0] out_data_r;

  lsi2c_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  tick_r, tick_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] count_r, count_nxt;
  logic        status_r, status_nxt;
  logic        sda_hold_r, sda_hold_nxt;
  logic        scl_o, sda_o, busy_o, done_o;

  logic advance;
  logic in_fire;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == lsi2c_pkg::REG_DEV_ADDR);
  assign cfg_prdata = (cfg_paddr[2] == lsi2c_pkg::REG_DEV_ADDR) ? {25'd0, dev_addr_r} : 32'd0;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= lsi2c_pkg::DEV_ADDR_RST;
    end else if (cfg_wr) begin
      dev_addr_r <= cfg_pwdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r  <= in_tuser[0];
      s1_mode_r <= in_tuser[2:1];
      s1_cmd_r  <= in_tdata[7:0];
      s1_sda_r  <= in_tdata[8];
    end
  end

  always_comb begin
    logic idle;
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    mode_nxt     = mode_r;
    held_nxt     = held_r;
    count_nxt    = count_r;
    status_nxt   = status_r;
    scl_o        = 1'b1;
    sda_o        = 1'b1;
    busy_o       = 1'b1;
    done_o       = 1'b0;

    idle = !(phase_r inside {lsi2c_pkg::PH_START, lsi2c_pkg::PH_TXA, lsi2c_pkg::PH_RACKA,
                             lsi2c_pkg::PH_TXC, lsi2c_pkg::PH_RACKC, lsi2c_pkg::PH_RXH,
                             lsi2c_pkg::PH_MACKH, lsi2c_pkg::PH_RXL, lsi2c_pkg::PH_MACKL,
                             lsi2c_pkg::PH_STOP});
    if (idle) begin
      phase_nxt = lsi2c_pkg::PH_IDLE;
      if (s1_req_r && (s1_mode_r != lsi2c_pkg::MODE_NONE)) begin
        mode_nxt   = s1_mode_r;
        held_nxt   = s1_cmd_r;
        status_nxt = 1'b0;
        phase_nxt  = lsi2c_pkg::PH_START;
        tick_nxt   = 2'd0;
      end else begin
        busy_o = 1'b0;
      end
    end

    unique case (phase_nxt)
      lsi2c_pkg::PH_START: begin
        if (tick_nxt == 2'd0) begin
          tick_nxt = 2'd1;
        end else begin
          sda_o       = 1'b0;
          shift_nxt   = {dev_addr_r, (mode_nxt == lsi2c_pkg::MODE_READ)};
          bit_cnt_nxt = 4'd0;
          tick_nxt    = 2'd0;
          phase_nxt   = lsi2c_pkg::PH_TXA;
        end
      end
      lsi2c_pkg::PH_TXA, lsi2c_pkg::PH_TXC: begin
        if (bit_cnt_nxt >= lsi2c_pkg::BITS_PER_BYTE) begin
          scl_o     = 1'b0;
          sda_o     = sda_hold_r;
          tick_nxt  = 2'd0;
          phase_nxt = (phase_nxt == lsi2c_pkg::PH_TXA) ? lsi2c_pkg::PH_RACKA
                                                       : lsi2c_pkg::PH_RACKC;
        end else if (tick_nxt == 2'd0) begin
          scl_o    = 1'b0;
          sda_o    = sda_hold_r;
          tick_nxt = 2'd1;
        end else begin
          sda_o = shift_nxt[7];
          if (tick_nxt == 2'd1) begin
            scl_o    = 1'b0;
            tick_nxt = 2'd2;
          end else begin
            shift_nxt   = {shift_nxt[6:0], 1'b0};
            bit_cnt_nxt = bit_cnt_nxt + 4'd1;
            tick_nxt    = 2'd0;
          end
        end
      end
      lsi2c_pkg::PH_RACKA, lsi2c_pkg::PH_RACKC: begin
        if (tick_nxt == 2'd0) begin
          scl_o    = 1'b0;
          tick_nxt = 2'd1;
        end else if (tick_nxt == 2'd1) begin
          if (s1_sda_r) begin
            status_nxt = 1'b1;
          end
          tick_nxt = 2'd2;
        end else begin
          scl_o       = 1'b0;
          tick_nxt    = 2'd0;
          bit_cnt_nxt = 4'd0;
          if (status_nxt || (phase_nxt == lsi2c_pkg::PH_RACKC)
              || (mode_nxt == lsi2c_pkg::MODE_PROBE)) begin
            phase_nxt = lsi2c_pkg::PH_STOP;
          end else if (mode_nxt == lsi2c_pkg::MODE_CMD) begin
            shift_nxt = held_nxt;
            phase_nxt = lsi2c_pkg::PH_TXC;
          end else begin
            shift_nxt = 8'd0;
            phase_nxt = lsi2c_pkg::PH_RXH;
          end
        end
      end
      lsi2c_pkg::PH_RXH, lsi2c_pkg::PH_RXL: begin
        if (bit_cnt_nxt >= lsi2c_pkg::BITS_PER_BYTE) begin
          scl_o     = 1'b0;
          tick_nxt  = 2'd0;
          phase_nxt = (phase_nxt == lsi2c_pkg::PH_RXH) ? lsi2c_pkg::PH_MACKH
                                                       : lsi2c_pkg::PH_MACKL;
        end else if (tick_nxt == 2'd0) begin
          scl_o    = 1'b0;
          tick_nxt = 2'd1;
        end else begin
          shift_nxt   = {shift_nxt[6:0], s1_sda_r};
          bit_cnt_nxt = bit_cnt_nxt + 4'd1;
          tick_nxt    = 2'd0;
        end
      end
      lsi2c_pkg::PH_MACKH, lsi2c_pkg::PH_MACKL: begin
        if (tick_nxt == 2'd0) begin
          scl_o    = 1'b0;
          sda_o    = sda_hold_r;
          tick_nxt = 2'd1;
        end else if (tick_nxt == 2'd1) begin
          scl_o    = 1'b0;
          sda_o    = (phase_nxt == lsi2c_pkg::PH_MACKL);
          tick_nxt = 2'd2;
        end else if (tick_nxt == 2'd2) begin
          sda_o    = (phase_nxt == lsi2c_pkg::PH_MACKL);
          tick_nxt = 2'd3;
        end else begin
          scl_o       = 1'b0;
          tick_nxt    = 2'd0;
          bit_cnt_nxt = 4'd0;
          if (phase_nxt == lsi2c_pkg::PH_MACKL) begin
            count_nxt = {held_nxt, shift_nxt};
            phase_nxt = lsi2c_pkg::PH_STOP;
          end else begin
            held_nxt  = shift_nxt;
            shift_nxt = 8'd0;
            phase_nxt = lsi2c_pkg::PH_RXL;
          end
        end
      end
      lsi2c_pkg::PH_STOP: begin
        if (tick_nxt == 2'd0) begin
          scl_o    = 1'b0;
          sda_o    = 1'b0;
          tick_nxt = 2'd1;
        end else if (tick_nxt == 2'd1) begin
          sda_o    = 1'b0;
          tick_nxt = 2'd2;
        end else begin
          done_o    = 1'b1;
          tick_nxt  = 2'd0;
          phase_nxt = lsi2c_pkg::PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    sda_hold_nxt = sda_o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lsi2c_pkg::PH_IDLE;
      tick_r     <= 2'd0;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      mode_r     <= lsi2c_pkg::MODE_CMD;
      held_r     <= 8'd0;
      count_r    <= 16'd0;
      status_r   <= 1'b0;
      sda_hold_r <= 1'b1;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      mode_r     <= mode_nxt;
      held_r     <= held_nxt;
      count_r    <= count_nxt;
      status_r   <= status_nxt;
      sda_hold_r <= sda_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {count_nxt, status_nxt, done_o, busy_o, sda_o, scl_o};
    end
  end

`include "light_sensor_i2c_master_top_assert.svh"

  `LSI_ASSERT_NOW(a_done_busy, out_tvalid && out_tdata[3], out_tdata[2], "done without busy")
  `LSI_ASSERT_NOW(a_idle_released, out_tvalid && !out_tdata[2], &out_tdata[1:0], "idle pins driven")
  `LSI_ASSERT_NOW(a_bit_cnt_range, 1'b1, bit_cnt_r <= lsi2c_pkg::BITS_PER_BYTE, "bit count overrun")
  `LSI_ASSERT_NEXT(a_s1_hold, s1_valid_r && !advance, s1_valid_r, "input item dropped")

endmodule
